[sv/drab_pkg.sv]
// ----------------------------------------------------------------------------
// drab_pkg
// Shared types and constants for the depth row angle binner.
// ----------------------------------------------------------------------------
package drab_pkg;

    localparam int ROW_WIDTH    = 640;
    localparam int COL_W        = 10;
    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 25;
    localparam int DIV_STEPS    = 42;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [9:0]  CENTER_RESET = 10'd320;
    localparam logic [15:0] FOCAL_RESET  = 16'd24407;
    localparam logic [6:0]  BEARING_MAX  = 7'd90;
    localparam logic [15:0] RANGE_SAT    = 16'hFFFF;

    localparam logic [2:0] ADDR_CENTER = 3'd0;
    localparam logic [2:0] ADDR_FOCAL  = 3'd4;

    typedef struct packed {
        logic [15:0]      depth;
        logic [COL_W-1:0] col;
        logic             neg;
        logic [COL_W-1:0] mag;
    } item_t;

    function automatic logic [29:0] atan_q24(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            5'd24: v = 30'd57;
            5'd25: v = 30'd29;
            5'd26: v = 30'd14;
            5'd27: v = 30'd7;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

[sv/drab_front.sv]
// ----------------------------------------------------------------------------
// drab_front
// Accepts depth pixels, tracks the column and classifies each pixel by its
// offset from the optical center.
// ----------------------------------------------------------------------------
module drab_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [drab_pkg::COL_W-1:0] center,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // depth_mm
    output logic                     push,
    input  logic                     push_ready,
    output drab_pkg::item_t          push_item
);

    logic [drab_pkg::COL_W-1:0] column_index_reg;
    logic [drab_pkg::COL_W-1:0] column_index_next;

    assign s_tready = push_ready;
    assign push     = s_tvalid && push_ready;

    always_comb begin
        push_item.depth = s_tdata;
        push_item.col   = column_index_reg;
        push_item.neg   = column_index_reg < center;
        push_item.mag   = push_item.neg ? center - column_index_reg
                                        : column_index_reg - center;
    end

    always_comb begin
        column_index_next = column_index_reg;
        if (push) begin
            if ({1'b0, column_index_reg} >= (drab_pkg::COL_W+1)'(drab_pkg::ROW_WIDTH - 1)) begin
                column_index_next = '0;
            end else begin
                column_index_next = column_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg <= '0;
        end else begin
            column_index_reg <= column_index_next;
        end
    end

endmodule

[sv/drab_queue.sv]
// ----------------------------------------------------------------------------
// drab_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module drab_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    output logic            push_ready,
    input  drab_pkg::item_t push_item,
    input  logic            pop,
    output logic            pop_valid,
    output drab_pkg::item_t pop_item
);

    drab_pkg::item_t mem [drab_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = count_reg != 2'(drab_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/drab_back.sv]
// ----------------------------------------------------------------------------
// drab_back
// Per-pixel bearing (cordic), slant range (square root and division) and
// bearing bin accumulation with mean output.
// ----------------------------------------------------------------------------
module drab_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [15:0]                focal,
    input  logic                       pop_valid,
    output logic                       pop,
    input  drab_pkg::item_t            pop_item,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata    // mean_range_mm, bearing_deg
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL  = 9'b000000010,
        ST_ADD  = 9'b000000100,
        ST_SQRT = 9'b000001000,
        ST_RMUL = 9'b000010000,
        ST_RDIV = 9'b000100000,
        ST_BIN  = 9'b001000000,
        ST_MDIV = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]                depth_reg, depth_next;
    logic [drab_pkg::COL_W-1:0] col_reg, col_next;
    logic                       neg_reg, neg_next;
    logic [drab_pkg::COL_W-1:0] mag_reg, mag_next;

    logic signed [39:0] x_reg, x_next;
    logic signed [39:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0]         ci_reg, ci_next;

    logic [31:0] ff_reg, ff_next;
    logic [31:0] dd_reg, dd_next;
    logic [48:0] v_reg, v_next;
    logic [48:0] r_reg, r_next;
    logic [4:0]  k_reg, k_next;

    logic [41:0] num_reg, num_next;
    logic [23:0] rem_reg, rem_next;
    logic [23:0] div_reg, div_next;
    logic [5:0]  dcnt_reg, dcnt_next;

    logic [7:0]  cur_bearing_reg, cur_bearing_next;
    logic [26:0] range_sum_reg, range_sum_next;
    logic [10:0] group_count_reg, group_count_next;
    logic [7:0]  bin_bearing_reg, bin_bearing_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_mean_reg, out_mean_next;
    logic [7:0]  out_bearing_reg, out_bearing_next;

    logic [15:0]        f_eff;
    logic [15:0]        d64;
    logic signed [39:0] xs, ys, y_abs;
    logic [48:0]        sq_bit, sq_trial;
    logic [24:0]        trial, rem_sub;
    logic               ge;
    logic [33:0]        z_clip, z_round;
    logic [9:0]         b_mag;
    logic [6:0]         b_clamp;
    logic [7:0]         bearing;
    logic [15:0]        rng;
    logic [10:0]        cnt_eff;
    logic [40:0]        rmul;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bearing_reg, out_mean_reg};

    always_comb begin
        f_eff    = (focal == 16'd0) ? 16'd1 : focal;
        d64      = {mag_reg, 6'b0};
        xs       = x_reg >>> ci_reg;
        y_abs    = -y_reg;
        ys       = y_reg[39] ? -(y_abs >>> ci_reg) : (y_reg >>> ci_reg);
        sq_bit   = 49'd1 << {k_reg, 1'b0};
        sq_trial = r_reg + sq_bit;
        trial    = {rem_reg, num_reg[41]};
        ge       = trial >= {1'b0, div_reg};
        rem_sub  = trial - {1'b0, div_reg};
        z_clip   = z_reg[33] ? 34'd0 : z_reg;
        z_round  = z_clip + 34'd8388608;
        b_mag    = z_round[33:24];
        b_clamp  = (b_mag > {3'b0, drab_pkg::BEARING_MAX}) ? drab_pkg::BEARING_MAX
                                                           : b_mag[6:0];
        bearing  = neg_reg ? -{1'b0, b_clamp} : {1'b0, b_clamp};
        rng      = (num_reg[41:16] != 26'd0) ? drab_pkg::RANGE_SAT : num_reg[15:0];
        cnt_eff  = (group_count_reg == 11'd0) ? 11'd1 : group_count_reg;
        rmul     = depth_reg * r_reg[24:0];
    end

    always_comb begin
        state_next       = state_reg;
        depth_next       = depth_reg;
        col_next         = col_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        ci_next          = ci_reg;
        ff_next          = ff_reg;
        dd_next          = dd_reg;
        v_next           = v_reg;
        r_next           = r_reg;
        k_next           = k_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        dcnt_next        = dcnt_reg;
        cur_bearing_next = cur_bearing_reg;
        range_sum_next   = range_sum_reg;
        group_count_next = group_count_reg;
        bin_bearing_next = bin_bearing_reg;
        out_valid_next   = out_valid_reg;
        out_mean_next    = out_mean_reg;
        out_bearing_next = out_bearing_reg;
        pop              = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // cordic vectoring runs alongside the range path
        if ({1'b0, ci_reg} < 6'(drab_pkg::CORDIC_STEPS)) begin
            if (!y_reg[39]) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + 34'(drab_pkg::atan_q24(ci_reg));
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - 34'(drab_pkg::atan_q24(ci_reg));
            end
            ci_next = ci_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    pop        = 1'b1;
                    depth_next = pop_item.depth;
                    col_next   = pop_item.col;
                    neg_next   = pop_item.neg;
                    mag_next   = pop_item.mag;
                    x_next     = 40'({f_eff, 20'b0});
                    y_next     = 40'({pop_item.mag, 26'b0});
                    z_next     = '0;
                    ci_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ff_next    = f_eff * f_eff;
                dd_next    = d64 * d64;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                v_next     = {({1'b0, ff_reg} + {1'b0, dd_reg}), 16'b0};
                r_next     = '0;
                k_next     = 5'(drab_pkg::SQRT_STEPS - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (v_reg >= sq_trial) begin
                    v_next = v_reg - sq_trial;
                    r_next = (r_reg >> 1) + sq_bit;
                end else begin
                    r_next = r_reg >> 1;
                end
                k_next = k_reg - 1'b1;
                if (k_reg == 5'd0) begin
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL: begin
                num_next   = {1'b0, rmul} + 42'({f_eff, 7'b0});
                div_next   = {f_eff, 8'b0};
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_RDIV;
            end
            ST_RDIV: begin
                rem_next  = ge ? rem_sub[23:0] : trial[23:0];
                num_next  = {num_reg[40:0], ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 6'(drab_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                if ({1'b0, ci_reg} == 6'(drab_pkg::CORDIC_STEPS)) begin
                    cur_bearing_next = bearing;
                    if (col_reg == '0) begin
                        range_sum_next   = 27'(rng);
                        group_count_next = 11'd1;
                        state_next       = ST_IDLE;
                    end else if (bearing == cur_bearing_reg) begin
                        range_sum_next   = range_sum_reg + 27'(rng);
                        group_count_next = group_count_reg + 1'b1;
                        state_next       = ST_IDLE;
                    end else begin
                        num_next         = 42'({1'b0, range_sum_reg} +
                                               28'(cnt_eff >> 1));
                        div_next         = 24'(cnt_eff);
                        rem_next         = '0;
                        dcnt_next        = '0;
                        bin_bearing_next = cur_bearing_reg;
                        range_sum_next   = 27'(rng);
                        group_count_next = 11'd1;
                        state_next       = ST_MDIV;
                    end
                end
            end
            ST_MDIV: begin
                rem_next  = ge ? rem_sub[23:0] : trial[23:0];
                num_next  = {num_reg[40:0], ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 6'(drab_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next   = 1'b1;
                    out_mean_next    = rng;
                    out_bearing_next = bin_bearing_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        depth_reg       <= depth_next;
        col_reg         <= col_next;
        neg_reg         <= neg_next;
        mag_reg         <= mag_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        z_reg           <= z_next;
        ff_reg          <= ff_next;
        dd_reg          <= dd_next;
        v_reg           <= v_next;
        r_reg           <= r_next;
        k_reg           <= k_next;
        num_reg         <= num_next;
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        dcnt_reg        <= dcnt_next;
        bin_bearing_reg <= bin_bearing_next;
        out_mean_reg    <= out_mean_next;
        out_bearing_reg <= out_bearing_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ci_reg          <= 5'(drab_pkg::CORDIC_STEPS);
            cur_bearing_reg <= '0;
            range_sum_reg   <= '0;
            group_count_reg <= 11'd1;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            ci_reg          <= ci_next;
            cur_bearing_reg <= cur_bearing_next;
            range_sum_reg   <= range_sum_next;
            group_count_reg <= group_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // a bin always holds at least one pixel
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        group_count_reg != 11'd0)
        else $error("group count zero");

    // divider remainder stays below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDIV || state_reg == ST_MDIV) |-> rem_reg < div_reg)
        else $error("divider remainder out of range");

    // a bin mean never needs saturation
    a_mean_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> num_reg[41:16] == 26'd0)
        else $error("mean exceeds 16 bits");

endmodule

[sv/depth_row_angle_binner.sv]
// ----------------------------------------------------------------------------
// depth_row_angle_binner
// Bins a row of depth pixels by whole-degree bearing and emits mean ranges.
// ----------------------------------------------------------------------------
// Each depth pixel passes through the back end as a 25-step square root and a
// 42-step restoring divider for the slant range, with the 28-step cordic run
// alongside; a pixel that closes a bearing bin also runs the mean division
// through the same divider. The front end takes a transfer whenever the
// two-entry queue has room.
module depth_row_angle_binner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // depth_mm
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // mean_range_mm, bearing_deg
);

    logic [9:0]  center_reg, center_next;
    logic [15:0] focal_reg, focal_next;
    logic        cfg_wr;

    logic            push, push_ready, pop, pop_valid;
    drab_pkg::item_t push_item, pop_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        center_next = center_reg;
        focal_next  = focal_reg;
        if (cfg_wr && paddr == drab_pkg::ADDR_CENTER) begin
            center_next = pwdata[9:0];
        end
        if (cfg_wr && paddr == drab_pkg::ADDR_FOCAL) begin
            focal_next = pwdata[15:0];
        end
    end

    always_comb begin
        priority if (paddr == drab_pkg::ADDR_CENTER) begin
            prdata = {22'b0, center_reg};
        end else if (paddr == drab_pkg::ADDR_FOCAL) begin
            prdata = {16'b0, focal_reg};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= drab_pkg::CENTER_RESET;
            focal_reg  <= drab_pkg::FOCAL_RESET;
        end else begin
            center_reg <= center_next;
            focal_reg  <= focal_next;
        end
    end

    drab_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .center     (center_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    drab_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    drab_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .focal     (focal_reg),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[dv/depth_row_angle_binner_tb.sv]
// ----------------------------------------------------------------------------
// depth_row_angle_binner_tb
// Streams depth rows through the binner under several center and focal
// settings, predicts each bin's mean range and bearing, and compares every
// result transfer in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module depth_row_angle_binner_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // depth_mm
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // mean_range_mm, bearing_deg

    typedef struct {
        logic [15:0] mean_mm;
        logic [7:0]  bearing;
    } bin_t;

    logic [15:0] depth_q[$];
    bin_t        bin_q[$];
    int          errors = 0;
    int          idle_mode = 0;
    bit          hold_req = 0;
    int          hold_cnt = 0;

    // binner state as seen from outside
    logic [9:0]  cfg_center = drab_pkg::CENTER_RESET;
    logic [15:0] cfg_focal = drab_pkg::FOCAL_RESET;
    int unsigned col_idx = 0;
    int          cur_brg = 0;
    longint unsigned rsum = 0;
    longint unsigned gcnt = 1;

    longint atan_tab[28] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7
    };

    depth_row_angle_binner u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint asr_trunc(longint v, int sh);
        return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int bearing_deg(longint unsigned mag, bit neg, longint unsigned f);
        longint x, y, z, xs, ys, b;
        x = longint'(f << 20);
        y = longint'(mag << 26);
        z = 0;
        for (int i = 0; i < 28; i++) begin
            xs = asr_trunc(x, i);
            ys = asr_trunc(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        b = (z + (64'd1 << 23)) >>> 24;
        if (b > 90) b = 90;
        return neg ? -int'(b) : int'(b);
    endfunction

    // advances the row state by one pixel, returns 1 when a bin closes
    function automatic bit bin_pixel(logic [15:0] depth, output bin_t res);
        longint unsigned f, mag, d64, s, rng, cnt, mean;
        bit neg;
        int brg;
        bit hit;
        hit = 0;
        res = '{default: '0};
        f = (cfg_focal == 0) ? 1 : cfg_focal;
        neg = col_idx < cfg_center;
        mag = neg ? cfg_center - col_idx : col_idx - cfg_center;
        d64 = mag << 6;
        s = int_sqrt((f * f + d64 * d64) << 16);
        rng = (depth * s + f * 128) / (f * 256);
        if (rng > 65535) rng = 65535;
        brg = bearing_deg(mag, neg, f);
        if (col_idx == 0) begin
            rsum = rng;
            gcnt = 1;
        end else if (brg == cur_brg) begin
            rsum = (rsum + rng) & 27'h7FFFFFF;
            gcnt = (gcnt + 1) & 11'h7FF;
        end else begin
            cnt = (gcnt == 0) ? 1 : gcnt;
            mean = (rsum + cnt / 2) / cnt;
            if (mean > 65535) mean = 65535;
            res.mean_mm = mean[15:0];
            res.bearing = cur_brg[7:0];
            hit = 1;
            rsum = rng;
            gcnt = 1;
        end
        cur_brg = brg;
        col_idx = (col_idx + 1 >= drab_pkg::ROW_WIDTH) ? 0 : col_idx + 1;
        return hit;
    endfunction

    function automatic void add_depth(logic [15:0] d);
        depth_q = {depth_q, d};
    endfunction

    function automatic bit idle_roll(bit sender);
        int pct;
        case (idle_mode)
            0: pct = sender ? 19 : 54;
            1: pct = sender ? 54 : 19;
            default: pct = 0;
        endcase
        return $urandom_range(99, 0) < pct;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (depth_q.size() != 0 && !idle_roll(1)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= depth_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
        else if (hold_req) hold_cnt <= 4000;
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (hold_cnt == 0) && !hold_req && !idle_roll(0);
    end

    // monitor
    always @(posedge aclk) begin
        bin_t res, want;
        if (aresetn && s_tvalid && s_tready) begin
            if (bin_pixel(s_tdata, res)) bin_q = {bin_q, res};
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (bin_q.size() == 0) begin
                report_mismatch("unexpected transfer, mean", m_tdata[15:0], -1);
            end else begin
                want = bin_q.pop_front();
                if (m_tdata[15:0] != want.mean_mm)
                    report_mismatch("mean_range_mm", m_tdata[15:0], want.mean_mm);
                if (m_tdata[23:16] != want.bearing)
                    report_mismatch("bearing_deg", $signed(m_tdata[23:16]),
                                    $signed(want.bearing));
            end
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == drab_pkg::ADDR_CENTER) cfg_center = data[9:0];
        else cfg_focal = data[15:0];
    endtask

    task automatic drain();
        while (depth_q.size() != 0 || s_tvalid || bin_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        int centers[6] = '{320, 0, 1023, 0, 500, 320};
        int focals[6]  = '{24407, 64, 65535, 0, 3000, 24407};
        logic [15:0] edge_depths[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                        16'h5555, 16'hAAAA, 16'h7FFF, 16'h00FF};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            idle_mode = ph / 2;
            if (ph != 0) begin
                reg_write(drab_pkg::ADDR_CENTER, centers[ph]);
                reg_write(drab_pkg::ADDR_FOCAL, focals[ph]);
            end
            if (ph == 0)
                for (int i = 0; i < 24; i++) add_depth(edge_depths[i % 8]);
            for (int i = 0; i < 180; i++) begin
                case ($urandom_range(3, 0))
                    0: add_depth(16'($urandom_range(4000, 0)));
                    1: add_depth(edge_depths[$urandom_range(7, 0)]);
                    default: add_depth(16'($urandom()));
                endcase
            end
            if (ph == 0) begin
                hold_req = 1;
                while (hold_cnt == 0) @(posedge aclk);
                hold_req = 0;
            end
            drain();
        end
        if (errors == 0) $display("depth_row_angle_binner_tb: done, clean");
        else $display("depth_row_angle_binner_tb: done, errors");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("depth_row_angle_binner_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
sv/drab_pkg.sv
sv/drab_front.sv
sv/drab_queue.sv
sv/drab_back.sv
sv/depth_row_angle_binner.sv
dv/depth_row_angle_binner_tb.sv
